[hdl/bounded_unique_key_bag_defines.svh]
// Assertion helpers for the key bag.
`ifndef BOUNDED_UNIQUE_KEY_BAG_DEFINES_SVH
`define BOUNDED_UNIQUE_KEY_BAG_DEFINES_SVH

// Same-cycle implication.
`define BUKB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bukb: same-cycle check failed");

// Next-cycle implication.
`define BUKB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bukb: next-cycle check failed");

`endif

[hdl/bukb_pkg.sv]
`timescale 1ns / 1ps

package bukb_pkg;

  localparam int KEY_FIELD_W = 32;
  localparam int SLOT_W      = 6;
  localparam int COUNT_W     = 7;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef struct packed {
    req_e                   req_type;
    logic [KEY_FIELD_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
  } out_t;

  // Control part of the search token that walks the cell chain.
  typedef struct packed {
    logic vld;
    req_e op;
    logic hit;
  } tok_ctl_t;

endpackage

[hdl/bounded_unique_key_bag.sv]
`timescale 1ns / 1ps
// Bounded bag of distinct keys, kept in slots 0..count-1.
// Input channel (in_valid_i/in_ready_o/in_data_i): one transaction is one
// request: add, remove, lookup or clear, plus a key (clear ignores the key).
// Output channel (out_valid_o/out_ready_i/out_data_o): exactly one result
// transaction per request: ok flag, slot and the count after the request.
// Each slot lives in one cell of a chain of CAPACITY cells. An accepted
// request becomes a token that steps one cell per cycle; each cell compares
// its key against the token, and the token also collects the last entry.
// When the token leaves the chain the count is updated and at most one cell
// is written (append on add, last entry moved into the hole on remove).
// The token passes the CAPACITY cell registers in order, and the result
// is then captured in the output register before it is offered.
// Only one request is in flight: the next request is taken only once the
// token of the previous one has left the whole chain.
// A new request is taken while a finished result still waits at the
// output; a second result is parked in a skid register, and the input
// stalls while a token is in flight or that skid register is full.
// Reset: count is zero, no token in flight, no result pending. Key storage
// is not cleared; slots at or above the count are never compared.
module bounded_unique_key_bag #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bukb_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bukb_pkg::out_t out_data_o
);

`include "bounded_unique_key_bag_defines.svh"

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // token chain wiring; index i feeds cell i, index CAPACITY is the tail
  bukb_pkg::tok_ctl_t   ctl_w  [CAPACITY+1];
  logic [KEY_WIDTH-1:0] key_w  [CAPACITY+1];
  logic [IDX_W-1:0]     pos_w  [CAPACITY+1];
  logic [KEY_WIDTH-1:0] last_w [CAPACITY+1];

  logic                 busy_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 out_valid_q, pend_valid_q;
  bukb_pkg::out_t       out_q, pend_q;

  logic                 in_fire, out_fire, tail_vld;
  logic [63:0]          key_ext;
  logic [KEY_WIDTH-1:0] key_in;

  bukb_pkg::out_t       res;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx, res_idx;
  logic [KEY_WIDTH-1:0] wr_data;
  logic [CAPACITY-1:0]  wr_sel;
  logic [15:0]          idx_ext, cnt_ext;

  assign in_ready_o = !busy_q && !pend_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign tail_vld   = ctl_w[CAPACITY].vld;

  // only the low KEY_WIDTH bits of the key take part
  assign key_ext = {32'd0, in_data_i.key};
  assign key_in  = key_ext[KEY_WIDTH-1:0];

  // token injection at cell 0
  always_comb begin
    ctl_w[0].vld = in_fire;
    ctl_w[0].op  = in_data_i.req_type;
    ctl_w[0].hit = 1'b0;
    key_w[0]     = key_in;
    pos_w[0]     = '0;
    last_w[0]    = '0;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign wr_sel[i] = wr_en && (wr_idx == IDX_W'(i));

    bukb_cell #(
      .KEY_W (KEY_WIDTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .count_i   (count_q),
      .ctl_i     (ctl_w[i]),
      .key_i     (key_w[i]),
      .pos_i     (pos_w[i]),
      .last_i    (last_w[i]),
      .ctl_o     (ctl_w[i+1]),
      .key_o     (key_w[i+1]),
      .pos_o     (pos_w[i+1]),
      .last_o    (last_w[i+1]),
      .wr_i      (wr_sel[i]),
      .wr_data_i (wr_data)
    );
  end

  // Resolve the request when the token leaves the chain.
  always_comb begin
    res_idx = '0;
    res.ok  = 1'b0;
    wr_en   = 1'b0;
    wr_idx  = '0;
    wr_data = key_w[CAPACITY];
    count_d = count_q;
    case (ctl_w[CAPACITY].op)
      bukb_pkg::REQ_ADD: begin
        if ((count_q < CNT_W'(CAPACITY)) && !ctl_w[CAPACITY].hit) begin
          res.ok  = 1'b1;
          res_idx = count_q[IDX_W-1:0];
          wr_en   = tail_vld;
          wr_idx  = count_q[IDX_W-1:0];
          count_d = count_q + CNT_W'(1);
        end
      end
      bukb_pkg::REQ_REMOVE: begin
        // hole at the match gets the last entry
        if (ctl_w[CAPACITY].hit) begin
          res.ok  = 1'b1;
          res_idx = pos_w[CAPACITY];
          wr_en   = tail_vld;
          wr_idx  = pos_w[CAPACITY];
          wr_data = last_w[CAPACITY];
          count_d = count_q - CNT_W'(1);
        end
      end
      bukb_pkg::REQ_LOOKUP: begin
        if (ctl_w[CAPACITY].hit) begin
          res.ok  = 1'b1;
          res_idx = pos_w[CAPACITY];
        end
      end
      default: begin
        res.ok  = 1'b1;
        count_d = '0;
      end
    endcase
    idx_ext   = 16'(res_idx);
    cnt_ext   = 16'(count_d);
    res.slot  = idx_ext[bukb_pkg::SLOT_W-1:0];
    res.count = cnt_ext[bukb_pkg::COUNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (tail_vld) begin
        busy_q <= 1'b0;
      end
      if (tail_vld) begin
        count_q <= count_d;
        // skid is always empty here: input stalls while it is full
        if (!out_valid_q || out_fire) begin
          out_valid_q <= 1'b1;
        end else begin
          pend_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        if (pend_valid_q) begin
          pend_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_vld) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        pend_q <= res;
      end
    end else if (out_fire && pend_valid_q) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // count never exceeds capacity
  `BUKB_ASSERT_IMPLY(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(CAPACITY))
  // one request in flight: accept blocks the input next cycle
  `BUKB_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_fire, busy_q && !in_ready_o)
  // a token leaves the chain only for an accepted request
  `BUKB_ASSERT_IMPLY(a_tail_busy, clk_i, rst_ni, tail_vld, busy_q)
  // skid register only fills behind a held output
  `BUKB_ASSERT_IMPLY(a_skid_order, clk_i, rst_ni, pend_valid_q, out_valid_q)

endmodule

[hdl/bukb_cell.sv]
`timescale 1ns / 1ps

module bukb_cell #(
  parameter int KEY_W = 32,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CNT_W-1:0]   count_i,
  input  bukb_pkg::tok_ctl_t ctl_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [IDX_W-1:0]   pos_i,
  input  logic [KEY_W-1:0]   last_i,
  output bukb_pkg::tok_ctl_t ctl_o,
  output logic [KEY_W-1:0]   key_o,
  output logic [IDX_W-1:0]   pos_o,
  output logic [KEY_W-1:0]   last_o,
  input  logic               wr_i,
  input  logic [KEY_W-1:0]   wr_data_i
);

  logic [KEY_W-1:0]   store_q;
  bukb_pkg::tok_ctl_t ctl_d, ctl_q;
  logic [KEY_W-1:0]   key_q;
  logic [IDX_W-1:0]   pos_d, pos_q;
  logic [KEY_W-1:0]   last_d, last_q;
  logic               occ, is_last, match;

  always_comb begin
    occ     = (count_i > CNT_W'(IDX));
    is_last = (count_i == CNT_W'(IDX + 1));
    match   = ctl_i.vld && !ctl_i.hit && occ && (store_q == key_i);
    ctl_d   = ctl_i;
    pos_d   = pos_i;
    last_d  = last_i;
    // first match wins; later cells see hit already set
    if (match) begin
      ctl_d.hit = 1'b1;
      pos_d     = IDX_W'(IDX);
    end
    // pick up the tail entry for a possible remove
    if (ctl_i.vld && is_last) begin
      last_d = store_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_i;
    pos_q  <= pos_d;
    last_q <= last_d;
    if (wr_i) begin
      store_q <= wr_data_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign key_o  = key_q;
  assign pos_o  = pos_q;
  assign last_o = last_q;

endmodule
